[rtl/krt_pkg.sv]
// Shared types, codes and constants for the keyed record table.
// Used by the top level and the port checker; depends on nothing.
package krt_pkg;

  localparam int unsigned TableDepth = 32;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_LIST   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NEG       = 3'd1,
    STATUS_DUP       = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_FULL      = 3'd4,
    STATUS_EMPTY     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_OUT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic [63:0]        name_tag;
    logic signed [31:0] quantity;
    logic signed [31:0] price;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic [63:0]        out_name_tag;
    logic signed [31:0] out_quantity;
    logic signed [31:0] out_price;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name_tag;
    logic signed [31:0] quantity;
    logic signed [31:0] price;
  } rec_t;

  function automatic out_t status_word(status_e s);
    out_t w;
    w        = '0;
    w.status = s;
    w.last   = 1'b1;
    return w;
  endfunction

  function automatic out_t record_word(rec_t r, logic last);
    out_t w;
    w.status       = STATUS_OK;
    w.out_key      = r.key;
    w.out_name_tag = r.name_tag;
    w.out_quantity = r.quantity;
    w.out_price    = r.price;
    w.last         = last;
    return w;
  endfunction

endpackage

[rtl/krt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/keyed_record_table_top.sv]
// Keyed record table: insert, delete, lookup, update and list over one record RAM.
// Insert, lookup, update scan the records with one RAM read per entry scanned.
// Delete scans, then shifts later records down; list reads out every record in turn.
// A result waits in the output register; the next word is taken once the result is loaded.
// Reset clears the record count and control state; the record RAM is not cleared.
// Uses krt_pkg and krt_ram.
module keyed_record_table_top #(
  parameter int unsigned TABLE_DEPTH = krt_pkg::TableDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  krt_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output krt_pkg::out_t out_word_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);

  krt_pkg::state_e state_q, state_d;
  krt_pkg::in_t    word_q, word_d;
  krt_pkg::out_t   res_q, res_d;
  krt_pkg::out_t   out_q, out_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   rd_idx_q, rd_idx_d;
  logic            rd_v_q, rd_v_d;
  logic            out_valid_q, out_valid_d;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  krt_pkg::rec_t   rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  krt_pkg::rec_t   wr_data;

  logic            in_fire;
  logic            out_free;
  logic            hit;
  logic            miss;
  logic            ptr_in_range;
  logic [CW-1:0]   ptr_next;
  logic [CW-1:0]   rd_next;
  logic [CW-1:0]   dst_idx;
  logic            neg_insert;
  logic            neg_update;

  krt_ram #(
    .WIDTH ($bits(krt_pkg::rec_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_krt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o   = (state_q != krt_pkg::S_IDLE);
  assign in_fire      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign ptr_in_range = (ptr_q < count_q);
  assign ptr_next     = ptr_q + CW'(1);
  assign rd_next      = rd_idx_q + CW'(1);
  assign dst_idx      = rd_idx_q - CW'(1);
  assign hit          = rd_v_q && (rd_data.key == word_q.key);
  assign miss         = (count_q == '0) || (rd_v_q && !hit && (rd_next == count_q));
  assign neg_insert   = in_word_i.key[31] || in_word_i.quantity[31] || in_word_i.price[31];
  assign neg_update   = in_word_i.quantity[31] || in_word_i.price[31];

  always_comb begin
    state_d = state_q;
    case (state_q)
      krt_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_word_i.cmd)
            krt_pkg::CMD_INSERT: state_d = neg_insert ? krt_pkg::S_RESP : krt_pkg::S_SCAN;
            krt_pkg::CMD_DELETE: state_d = krt_pkg::S_SCAN;
            krt_pkg::CMD_LOOKUP: state_d = krt_pkg::S_SCAN;
            krt_pkg::CMD_UPDATE: state_d = neg_update ? krt_pkg::S_RESP : krt_pkg::S_SCAN;
            krt_pkg::CMD_LIST: begin
              state_d = (count_q == '0) ? krt_pkg::S_RESP : krt_pkg::S_LIST_RD;
            end
            default: state_d = krt_pkg::S_IDLE;
          endcase
        end
      end
      krt_pkg::S_SCAN: begin
        if (hit) begin
          state_d = (word_q.cmd == krt_pkg::CMD_DELETE) ? krt_pkg::S_SHIFT : krt_pkg::S_RESP;
        end else if (miss) begin
          state_d = krt_pkg::S_RESP;
        end
      end
      krt_pkg::S_SHIFT: begin
        if (!ptr_in_range && !rd_v_q) begin
          state_d = krt_pkg::S_RESP;
        end
      end
      krt_pkg::S_LIST_RD: state_d = krt_pkg::S_LIST_OUT;
      krt_pkg::S_LIST_OUT: begin
        if (out_free) begin
          state_d = (ptr_next == count_q) ? krt_pkg::S_IDLE : krt_pkg::S_LIST_RD;
        end
      end
      krt_pkg::S_RESP: begin
        if (out_free) begin
          state_d = krt_pkg::S_IDLE;
        end
      end
      default: state_d = krt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    word_d      = word_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    count_d     = count_q;
    ptr_d       = ptr_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    rd_en       = 1'b0;
    rd_addr     = ptr_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = rd_idx_q[AW-1:0];
    wr_data     = '{key: word_q.key, name_tag: word_q.name_tag,
                    quantity: word_q.quantity, price: word_q.price};
    case (state_q)
      krt_pkg::S_IDLE: begin
        if (in_fire) begin
          word_d = in_word_i;
          ptr_d  = '0;
          case (in_word_i.cmd)
            krt_pkg::CMD_INSERT: begin
              if (neg_insert) begin
                res_d = krt_pkg::status_word(krt_pkg::STATUS_NEG);
              end
            end
            krt_pkg::CMD_UPDATE: begin
              if (neg_update) begin
                res_d = krt_pkg::status_word(krt_pkg::STATUS_NEG);
              end
            end
            krt_pkg::CMD_LIST: begin
              if (count_q == '0) begin
                res_d = krt_pkg::status_word(krt_pkg::STATUS_EMPTY);
              end
            end
            default: res_d = res_q;
          endcase
        end
      end
      krt_pkg::S_SCAN: begin
        rd_en    = ptr_in_range;
        rd_v_d   = ptr_in_range;
        rd_idx_d = ptr_q;
        if (ptr_in_range) begin
          ptr_d = ptr_next;
        end
        if (hit) begin
          case (word_q.cmd)
            krt_pkg::CMD_INSERT: res_d = krt_pkg::status_word(krt_pkg::STATUS_DUP);
            krt_pkg::CMD_DELETE: begin
              ptr_d  = rd_next;
              rd_v_d = 1'b0;
            end
            krt_pkg::CMD_LOOKUP: res_d = krt_pkg::record_word(rd_data, 1'b1);
            krt_pkg::CMD_UPDATE: begin
              wr_en   = 1'b1;
              wr_addr = rd_idx_q[AW-1:0];
              res_d   = krt_pkg::status_word(krt_pkg::STATUS_OK);
            end
            default: res_d = res_q;
          endcase
        end else if (miss) begin
          if (word_q.cmd == krt_pkg::CMD_INSERT) begin
            if (count_q == FullCount) begin
              res_d = krt_pkg::status_word(krt_pkg::STATUS_FULL);
            end else begin
              wr_en   = 1'b1;
              wr_addr = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              res_d   = krt_pkg::status_word(krt_pkg::STATUS_OK);
            end
          end else begin
            res_d = krt_pkg::status_word(krt_pkg::STATUS_NOT_FOUND);
          end
        end
      end
      krt_pkg::S_SHIFT: begin
        rd_en    = ptr_in_range;
        rd_v_d   = ptr_in_range;
        rd_idx_d = ptr_q;
        if (ptr_in_range) begin
          ptr_d = ptr_next;
        end
        if (rd_v_q) begin
          wr_en   = 1'b1;
          wr_addr = dst_idx[AW-1:0];
          wr_data = rd_data;
        end
        if (!ptr_in_range && !rd_v_q) begin
          count_d = count_q - CW'(1);
          res_d   = krt_pkg::status_word(krt_pkg::STATUS_OK);
        end
      end
      krt_pkg::S_LIST_RD: begin
        rd_en = 1'b1;
      end
      krt_pkg::S_LIST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = krt_pkg::record_word(rd_data, ptr_next == count_q);
          ptr_d       = ptr_next;
        end
      end
      krt_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= krt_pkg::S_IDLE;
      count_q     <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    res_q    <= res_d;
    out_q    <= out_d;
    ptr_q    <= ptr_d;
    rd_idx_q <= rd_idx_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[rtl/krt_checker.sv]
// Port-level checks for the keyed record table, bound to the top level.
// Uses krt_pkg; sees only the ports of keyed_record_table_top.
module krt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input krt_pkg::in_t  in_word_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input krt_pkg::out_t out_word_o
);

  logic out_fire;
  logic in_fire;

  assign out_fire = out_valid_o && !out_stall_i;
  assign in_fire  = in_valid_i && !in_stall_o;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // error and empty results are single, final and carry no record
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != krt_pkg::STATUS_OK) |->
      out_word_o.last && (out_word_o.out_key == '0) && (out_word_o.out_name_tag == '0)
      && (out_word_o.out_quantity == '0) && (out_word_o.out_price == '0))
    else $error("error result not final or carries record data");

  // a listed record never carries a negative key, quantity or price
  a_rec_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == krt_pkg::STATUS_OK) |->
      !out_word_o.out_key[31] && !out_word_o.out_quantity[31] && !out_word_o.out_price[31])
    else $error("returned record has a negative field");

  // take no input word while a non-final list word is delivered
  a_list_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !out_word_o.last |-> !in_fire)
    else $error("input word taken in the middle of a list");

endmodule

bind keyed_record_table_top krt_checker u_krt_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for keyed_record_table_top: directed and random command words checked
// reply by reply against a record table kept inside the bench.
// Depends on krt_pkg and the RTL of keyed_record_table_top.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 2 * krt_pkg::TableDepth + 16;
  localparam int unsigned PRINT_CAP = 100;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] KEY_MIN = 32'h8000_0000;
  localparam logic [63:0] TAG_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  krt_pkg::in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  krt_pkg::out_t out_word;

  krt_pkg::in_t cmd_queue[$];
  krt_pkg::out_t reply_queue[$];
  krt_pkg::rec_t table_recs[krt_pkg::TableDepth];
  int unsigned table_count = 0;
  int unsigned table_peak = 0;
  int unsigned full_rejects = 0;
  int unsigned list_cmds = 0;
  int unsigned words_sent = 0;
  int unsigned sent_total = 0;
  int unsigned replies_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  keyed_record_table_top DUT (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_word_i(in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o(out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned find_slot(logic [31:0] k);
    for (int unsigned i = 0; i < table_count; i++) begin
      if (table_recs[i].key == k) return i;
    end
    return table_count;
  endfunction

  task automatic table_step(krt_pkg::in_t w);
    krt_pkg::out_t r;
    int unsigned slot;
    bit one_reply;
    r = '0;
    r.last = 1'b1;
    one_reply = 1'b1;
    slot = find_slot(w.key);
    case (w.cmd)
      krt_pkg::CMD_INSERT: begin
        if (w.key[31] || w.quantity[31] || w.price[31]) begin
          r.status = krt_pkg::STATUS_NEG;
        end else if (slot < table_count) begin
          r.status = krt_pkg::STATUS_DUP;
        end else if (table_count >= krt_pkg::TableDepth) begin
          r.status = krt_pkg::STATUS_FULL;
          full_rejects++;
        end else begin
          table_recs[table_count] = '{key: w.key, name_tag: w.name_tag,
                                      quantity: w.quantity, price: w.price};
          table_count++;
          if (table_count > table_peak) table_peak = table_count;
          r.status = krt_pkg::STATUS_OK;
        end
      end
      krt_pkg::CMD_DELETE: begin
        if (slot >= table_count) begin
          r.status = krt_pkg::STATUS_NOT_FOUND;
        end else begin
          for (int unsigned i = slot; i + 1 < table_count; i++) begin
            table_recs[i] = table_recs[i + 1];
          end
          table_count--;
          r.status = krt_pkg::STATUS_OK;
        end
      end
      krt_pkg::CMD_LOOKUP: begin
        if (slot >= table_count) begin
          r.status = krt_pkg::STATUS_NOT_FOUND;
        end else begin
          r.status       = krt_pkg::STATUS_OK;
          r.out_key      = table_recs[slot].key;
          r.out_name_tag = table_recs[slot].name_tag;
          r.out_quantity = table_recs[slot].quantity;
          r.out_price    = table_recs[slot].price;
        end
      end
      krt_pkg::CMD_UPDATE: begin
        if (w.quantity[31] || w.price[31]) begin
          r.status = krt_pkg::STATUS_NEG;
        end else if (slot >= table_count) begin
          r.status = krt_pkg::STATUS_NOT_FOUND;
        end else begin
          table_recs[slot].name_tag = w.name_tag;
          table_recs[slot].quantity = w.quantity;
          table_recs[slot].price    = w.price;
          r.status = krt_pkg::STATUS_OK;
        end
      end
      krt_pkg::CMD_LIST: begin
        list_cmds++;
        if (table_count == 0) begin
          r.status = krt_pkg::STATUS_EMPTY;
        end else begin
          one_reply = 1'b0;
          for (int unsigned i = 0; i < table_count; i++) begin
            r.status       = krt_pkg::STATUS_OK;
            r.out_key      = table_recs[i].key;
            r.out_name_tag = table_recs[i].name_tag;
            r.out_quantity = table_recs[i].quantity;
            r.out_price    = table_recs[i].price;
            r.last         = (i + 1 == table_count);
            reply_queue    = {reply_queue, r};
          end
        end
      end
      default: one_reply = 1'b0;
    endcase
    if (one_reply) reply_queue = {reply_queue, r};
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < PRINT_CAP) begin
      $display("tb: [%0t] reply %0d %s: got %h, want %h", $time, replies_seen, what, got,
               want);
    end
    error_count++;
  endtask

  task automatic check_reply(krt_pkg::out_t got);
    krt_pkg::out_t want;
    if (reply_queue.size() == 0) begin
      report_mismatch("word with nothing due, status", got.status, '0);
    end else begin
      want = reply_queue.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.out_key !== want.out_key) report_mismatch("key", got.out_key, want.out_key);
      if (got.out_name_tag !== want.out_name_tag) begin
        report_mismatch("name tag", got.out_name_tag, want.out_name_tag);
      end
      if (got.out_quantity !== want.out_quantity) begin
        report_mismatch("quantity", got.out_quantity, want.out_quantity);
      end
      if (got.out_price !== want.out_price) begin
        report_mismatch("price", got.out_price, want.out_price);
      end
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    end
    replies_seen++;
  endtask

  function automatic int unsigned draw_idle(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [31:0] pick_amount();
    if ($urandom_range(0, 99) < 12) return $urandom();
    return $urandom() & KEY_MAX;
  endfunction

  function automatic logic [31:0] pick_key(int unsigned pool);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return $urandom();
    if (r < 10) return KEY_MAX - $urandom_range(0, 3);
    return $urandom_range(0, pool - 1);
  endfunction

  function automatic logic [2:0] pick_cmd(int unsigned w_ins, int unsigned w_del,
                                          int unsigned w_lkp, int unsigned w_upd);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_ins) return krt_pkg::CMD_INSERT;
    if (r < w_ins + w_del) return krt_pkg::CMD_DELETE;
    if (r < w_ins + w_del + w_lkp) return krt_pkg::CMD_LOOKUP;
    if (r < w_ins + w_del + w_lkp + w_upd) return krt_pkg::CMD_UPDATE;
    if (r < 98) return krt_pkg::CMD_LIST;
    return CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
  endfunction

  task automatic queue_cmd(logic [2:0] c, logic [31:0] k, logic [63:0] tag,
                           logic [31:0] q, logic [31:0] p);
    krt_pkg::in_t w;
    w.cmd      = c;
    w.key      = k;
    w.name_tag = tag;
    w.quantity = q;
    w.price    = p;
    cmd_queue  = {cmd_queue, w};
  endtask

  task automatic queue_random(int unsigned n, int unsigned pool, int unsigned w_ins,
                              int unsigned w_del, int unsigned w_lkp, int unsigned w_upd);
    logic [2:0] c;
    int unsigned made;
    made = 0;
    while (made < n) begin
      c = pick_cmd(w_ins, w_del, w_lkp, w_upd);
      queue_cmd(c, pick_key(pool), {$urandom(), $urandom()}, pick_amount(), pick_amount());
      if (c < CMD_SPARE_FIRST) made++;
    end
  endtask

  // Driver: hold the word while stalled, advance once it is taken.
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      send_gap   <= 0;
      send_quiet <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        table_step(in_word);
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (cmd_queue.size() != 0) begin
          in_word  <= cmd_queue.pop_front();
          in_valid <= 1'b1;
          send_gap <= draw_idle(send_quiet);
          if ($urandom_range(0, 19) == 0) send_quiet <= !send_quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken reply word, then draw the next stall.
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      recv_quiet <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_reply(out_word);
      if ($urandom_range(0, 49) == 0) recv_quiet <= !recv_quiet;
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_draw = draw_idle(recv_quiet);
        out_stall  <= (stall_draw != 0);
        stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d of %0d words sent, %0d replies still due",
               cycle_count, words_sent, sent_total, reply_queue.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    queue_cmd(krt_pkg::CMD_LIST, 32'd0, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_LOOKUP, 32'd5, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_DELETE, 32'd5, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_UPDATE, 32'd5, 64'd1, 32'd1, 32'd1);
    queue_cmd(krt_pkg::CMD_INSERT, 32'd0, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_INSERT, KEY_MAX, TAG_ONES, KEY_MAX, KEY_MAX);
    queue_cmd(krt_pkg::CMD_INSERT, KEY_MIN, 64'd7, 32'd1, 32'd1);
    queue_cmd(krt_pkg::CMD_INSERT, 32'd9, 64'd7, KEY_MIN, 32'd1);
    queue_cmd(krt_pkg::CMD_INSERT, 32'd9, 64'd7, 32'd1, 32'hFFFF_FFFF);
    queue_cmd(krt_pkg::CMD_INSERT, 32'd0, 64'd3, 32'd3, 32'd3);
    queue_cmd(krt_pkg::CMD_LOOKUP, 32'd0, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_LOOKUP, KEY_MAX, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_LOOKUP, KEY_MIN, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_UPDATE, KEY_MAX, 64'd2, 32'hFFFF_FFFF, 32'd2);
    queue_cmd(krt_pkg::CMD_UPDATE, 32'd0, 64'd2, 32'd2, KEY_MIN);
    queue_cmd(krt_pkg::CMD_UPDATE, 32'd0, 64'hA5A5_5A5A_0F0F_F0F0, 32'd123, 32'h0000_0100);
    queue_cmd(krt_pkg::CMD_UPDATE, 32'd77, 64'd2, 32'd2, 32'd2);
    queue_cmd(krt_pkg::CMD_DELETE, KEY_MIN, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_LIST, 32'd0, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_DELETE, 32'd0, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_DELETE, 32'd0, 64'd0, 32'd0, 32'd0);
    queue_cmd(krt_pkg::CMD_LIST, 32'd0, 64'd0, 32'd0, 32'd0);
    for (int unsigned i = 0; i < 3; i++) begin
      queue_cmd(CMD_SPARE_FIRST + 3'(i), $urandom(), {$urandom(), $urandom()}, $urandom(),
                $urandom());
    end
    // fill past capacity, churn, then drain
    queue_random(85, 40, 70, 5, 10, 8);
    queue_random(90, 48, 30, 20, 20, 20);
    queue_random(80, 40, 10, 55, 15, 10);
    sent_total = cmd_queue.size();

    repeat (11) @(posedge clk);
    @(negedge clk) rst_ni = 1'b1;

    while (words_sent < sent_total) @(posedge clk);
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d command words (%0d lists) sent, %0d reply words checked, %0d mismatches",
             sent_total, list_cmds, replies_seen, error_count);
    $display("tb: table peaked at %0d of %0d records; %0d inserts hit a full table",
             table_peak, krt_pkg::TableDepth, full_rejects);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/krt_pkg.sv
rtl/krt_ram.sv
rtl/keyed_record_table_top.sv
rtl/krt_checker.sv
dv/tb_top.sv
